@@ sv/ipv4dq_pkg.sv @@
// shared types and constants of the dotted-quad address parser
package ipv4dq_pkg;

  localparam int unsigned COUNT_WIDTH    = 16;
  localparam int unsigned CONSUMED_WIDTH = 16;
  localparam int unsigned ADDR_WIDTH     = 32;

  localparam logic [11:0] OCTET_MAX     = 12'd255;
  localparam logic [2:0]  OCTETS_NEEDED = 3'd4;
  localparam logic [7:0]  DOT_CHAR      = 8'h2E;
  localparam logic [7:0]  ZERO_CHAR     = 8'h30;
  localparam logic [7:0]  DIGIT_MAX     = 8'd9;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] octet_store;
    logic [7:0]            current_octet;
    logic [2:0]            octet_count;
    logic                  digit_seen;
    logic                  skip_rest;
  } parse_state_t;

  typedef struct packed {
    logic                      success;
    logic [ADDR_WIDTH-1:0]     address;
    logic [CONSUMED_WIDTH-1:0] consumed;
  } result_t;

endpackage

@@ sv/ipv4dq_req_if.sv @@
// request channel: one text byte with its last flag
interface ipv4dq_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

@@ sv/ipv4dq_rsp_if.sv @@
// result channel: parse outcome per buffer
interface ipv4dq_rsp_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [31:0] address;
  logic [15:0] consumed;

  modport source (output valid, output success, output address, output consumed,
                  input ready);
  modport sink (input valid, input success, input address, input consumed,
                output ready);
endinterface

@@ sv/ipv4dq_step.sv @@
// per-byte parser update and end-of-buffer result
module ipv4dq_step #(
  parameter int unsigned CountWidth = ipv4dq_pkg::COUNT_WIDTH
) (
  input  ipv4dq_pkg::parse_state_t state_i,
  input  logic [CountWidth-1:0]    count_i,
  input  logic [7:0]               byte_i,
  input  logic                     last_i,
  output ipv4dq_pkg::parse_state_t state_o,
  output logic [CountWidth-1:0]    count_o,
  output ipv4dq_pkg::result_t      result_o
);

  logic [7:0]                nibble;
  logic                      is_digit;
  logic [11:0]               new_value;
  logic                      fail;
  logic                      bump;
  ipv4dq_pkg::parse_state_t  nxt;
  logic [CountWidth-1:0]     cnt;

  assign nibble    = byte_i - ipv4dq_pkg::ZERO_CHAR;
  assign is_digit  = (nibble <= ipv4dq_pkg::DIGIT_MAX);
  assign new_value = {1'b0, state_i.current_octet, 3'b000}
                   + {3'b000, state_i.current_octet, 1'b0}
                   + {4'b0000, nibble};

  always_comb begin
    nxt  = state_i;
    fail = 1'b0;
    bump = 1'b0;
    if (!state_i.skip_rest) begin
      if (is_digit) begin
        if (new_value > ipv4dq_pkg::OCTET_MAX) begin
          fail = 1'b1;
        end else begin
          nxt.current_octet = new_value[7:0];
          if (!state_i.digit_seen) begin
            if (state_i.octet_count >= ipv4dq_pkg::OCTETS_NEEDED) begin
              fail = 1'b1;
            end else begin
              nxt.octet_count = state_i.octet_count + 3'd1;
              nxt.digit_seen  = 1'b1;
              bump            = 1'b1;
            end
          end else begin
            bump = 1'b1;
          end
        end
      end else if (byte_i == ipv4dq_pkg::DOT_CHAR) begin
        if (!state_i.digit_seen || state_i.octet_count >= ipv4dq_pkg::OCTETS_NEEDED) begin
          fail = 1'b1;
        end else begin
          nxt.octet_store   = {state_i.octet_store[ipv4dq_pkg::ADDR_WIDTH-9:0],
                               state_i.current_octet};
          nxt.current_octet = '0;
          nxt.digit_seen    = 1'b0;
          bump              = 1'b1;
        end
      end else begin
        nxt.skip_rest = 1'b1;
      end
    end
    if (fail) begin
      nxt.octet_count = '0;
      nxt.skip_rest   = 1'b1;
    end
    cnt = count_i;
    if (bump && (count_i != {CountWidth{1'b1}})) begin
      cnt = count_i + {{(CountWidth-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    result_o.success = (nxt.octet_count == ipv4dq_pkg::OCTETS_NEEDED);
    if (result_o.success) begin
      result_o.address  = {nxt.octet_store[ipv4dq_pkg::ADDR_WIDTH-9:0], nxt.current_octet};
      result_o.consumed = ipv4dq_pkg::CONSUMED_WIDTH'(cnt);
    end else begin
      result_o.address  = '0;
      result_o.consumed = '0;
    end
    if (last_i) begin
      state_o = '0;
      count_o = '0;
    end else begin
      state_o = nxt;
      count_o = cnt;
    end
  end

endmodule

@@ sv/ipv4_dotted_quad_parser.sv @@
// top level of the streaming dotted-quad address parser
// order: a byte is registered on acceptance, then updates the parser state;
//   the result of a buffer is registered when its last byte updates the state
// throughput: one byte per cycle unless a last byte waits on an untaken result
// reset: asynchronous, clears parser state, byte counter and both valid flags
module ipv4_dotted_quad_parser #(
  parameter int unsigned CountWidth = ipv4dq_pkg::COUNT_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ipv4dq_req_if.sink         req_i,
  ipv4dq_rsp_if.source       rsp_o
);

  logic                      in_valid_q;
  logic [7:0]                in_byte_q;
  logic                      in_last_q;
  logic                      advance;

  ipv4dq_pkg::parse_state_t  state_q, state_d;
  logic [CountWidth-1:0]     count_q, count_d;
  ipv4dq_pkg::result_t       result_d, result_q;
  logic                      out_valid_q, out_valid_d;

  assign advance     = in_valid_q && (!in_last_q || !out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_byte_q <= req_i.text_byte;
      in_last_q <= req_i.last_byte;
    end
  end

  ipv4dq_step #(
    .CountWidth (CountWidth)
  ) u_step (
    .state_i  (state_q),
    .count_i  (count_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .state_o  (state_d),
    .count_o  (count_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      count_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      result_q <= result_d;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.success  = result_q.success;
  assign rsp_o.address  = result_q.address;
  assign rsp_o.consumed = result_q.consumed;

endmodule

@@ tb/ipv4_dotted_quad_parser_tb.sv @@
// testbench of the dotted-quad address parser: byte streams in, parse results checked in order
module ipv4_dotted_quad_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] bytes_t[$];

  localparam int unsigned STALL_LIMIT = 2000;

  logic clk;
  logic rst_n;

  ipv4dq_req_if req_if ();
  ipv4dq_rsp_if rsp_if ();

  ipv4_dotted_quad_parser dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  // predicted parser state
  logic [ipv4dq_pkg::ADDR_WIDTH-1:0]  ip_store;
  logic [7:0]                         oct_val;
  logic [2:0]                         oct_num;
  logic                               have_digit;
  logic                               parse_done;
  logic [ipv4dq_pkg::COUNT_WIDTH-1:0] byte_total;

  ipv4dq_pkg::result_t expected_results[$];

  bit          sender_idles;
  bit          receiver_stalls;
  int unsigned bytes_sent;
  int unsigned buffers_sent;
  int unsigned results_checked;
  int unsigned addresses_parsed;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_parse();
    ip_store   = '0;
    oct_val    = '0;
    oct_num    = '0;
    have_digit = 1'b0;
    parse_done = 1'b0;
    byte_total = '0;
  endfunction

  function automatic void predict_byte(logic [7:0] ch, logic last);
    logic [7:0]          digit;
    int unsigned         value;
    bit                  bad;
    ipv4dq_pkg::result_t res;
    digit = ch - ipv4dq_pkg::ZERO_CHAR;
    bad   = 1'b0;
    if (!parse_done) begin
      if (digit <= ipv4dq_pkg::DIGIT_MAX) begin
        value = int'(oct_val) * 10 + int'(digit);
        if (value > ipv4dq_pkg::OCTET_MAX ||
            (!have_digit && oct_num >= ipv4dq_pkg::OCTETS_NEEDED)) begin
          bad = 1'b1;
        end else begin
          oct_val = value[7:0];
          if (!have_digit) begin
            oct_num    = oct_num + 3'd1;
            have_digit = 1'b1;
          end
          if (byte_total != '1) byte_total = byte_total + 1'b1;
        end
      end else if (ch == ipv4dq_pkg::DOT_CHAR) begin
        if (!have_digit || oct_num >= ipv4dq_pkg::OCTETS_NEEDED) begin
          bad = 1'b1;
        end else begin
          ip_store   = {ip_store[ipv4dq_pkg::ADDR_WIDTH-9:0], oct_val};
          oct_val    = '0;
          have_digit = 1'b0;
          if (byte_total != '1) byte_total = byte_total + 1'b1;
        end
      end else begin
        parse_done = 1'b1;
      end
    end
    if (bad) begin
      oct_num    = '0;
      parse_done = 1'b1;
    end
    if (last) begin
      res = '0;
      if (oct_num == ipv4dq_pkg::OCTETS_NEEDED) begin
        res.success  = 1'b1;
        res.address  = {ip_store[ipv4dq_pkg::ADDR_WIDTH-9:0], oct_val};
        res.consumed = ipv4dq_pkg::CONSUMED_WIDTH'(byte_total);
      end
      expected_results.push_back(res);
      clear_parse();
    end
  endfunction

  task automatic note_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic send_byte(logic [7:0] ch, logic last);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.text_byte <= ch;
    req_if.last_byte <= last;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_byte(ch, last);
    bytes_sent++;
  endtask

  task automatic send_buffer(bytes_t b);
    foreach (b[i]) send_byte(b[i], i == b.size() - 1);
    buffers_sent++;
  endtask

  task automatic send_text(string s);
    bytes_t b;
    foreach (s[i]) b.push_back(s[i]);
    send_buffer(b);
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic logic [7:0] text_char();
    int unsigned k;
    k = $urandom_range(0, 10);
    return (k == 10) ? ipv4dq_pkg::DOT_CHAR : ipv4dq_pkg::ZERO_CHAR + 8'(k);
  endfunction

  // mostly well-formed addresses, then bad octets, wrong octet counts, corrupted bytes, noise
  function automatic bytes_t make_buffer();
    bytes_t      b;
    string       digits;
    int unsigned kind;
    int unsigned octets;
    int unsigned big_at;
    int unsigned v;
    logic [7:0]  stop;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 12))
        b.push_back($urandom_range(0, 1) ? text_char() : 8'($urandom));
      return b;
    end
    octets = (kind == 7) ? $urandom_range(1, 6) : 4;
    big_at = (kind == 6) ? $urandom_range(0, 3) : 99;
    for (int i = 0; i < octets; i++) begin
      if (i != 0) b.push_back(ipv4dq_pkg::DOT_CHAR);
      if (kind == 7 && $urandom_range(0, 4) == 0) continue;
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = 255;
        default: v = $urandom_range(0, 255);
      endcase
      if (i == big_at) v = $urandom_range(256, 999);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) b.push_back(ipv4dq_pkg::ZERO_CHAR);
      digits = $sformatf("%0d", v);
      foreach (digits[k]) b.push_back(digits[k]);
    end
    if (b.size() == 0) b.push_back(ipv4dq_pkg::DOT_CHAR);
    if (kind == 8) b[$urandom_range(0, b.size() - 1)] = 8'($urandom);
    if ($urandom_range(0, 2) == 0) begin
      do stop = 8'($urandom);
      while ((stop >= ipv4dq_pkg::ZERO_CHAR &&
              stop <= ipv4dq_pkg::ZERO_CHAR + ipv4dq_pkg::DIGIT_MAX) ||
             stop == ipv4dq_pkg::DOT_CHAR);
      b.push_back(stop);
      repeat ($urandom_range(0, 6))
        b.push_back($urandom_range(0, 1) ? text_char() : 8'($urandom));
    end
    return b;
  endfunction

  task automatic test_directed_cases();
    bytes_t b;
    send_text("255.255.255.255");
    send_text("0.0.0.0");
    send_text("000.0000.00255.1");
    send_text("256.1.1.1");
    send_text("1.2.3.2550");
    send_text(".1.2.3");
    send_text("1..2.3");
    wait_for_results();
    send_text("1.2.3.4.");
    send_text("1.2.3.4.5");
    send_text("1.2.3");
    send_text("9");
    send_text("10.0.0.1/24");
    send_text("10.0.0.1:");
    send_text("x1.2.3.4");
    b = {8'h37, ipv4dq_pkg::DOT_CHAR, 8'h37, ipv4dq_pkg::DOT_CHAR, 8'h37,
         ipv4dq_pkg::DOT_CHAR, 8'h37, 8'h00, 8'hFF};
    send_buffer(b);
    b = {8'hFF};
    send_buffer(b);
    b = {ipv4dq_pkg::DOT_CHAR};
    send_buffer(b);
    wait_for_results();
  endtask

  task automatic test_random_buffers(int unsigned n_bytes);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      send_buffer(make_buffer());
      if ($urandom_range(0, 39) == 0) wait_for_results();
    end
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (receiver_stalls && $urandom_range(0, 2) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    ipv4dq_pkg::result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        note_error($sformatf("unexpected result success=%0b address=%h consumed=%0d",
                             rsp_if.success, rsp_if.address, rsp_if.consumed));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.success) addresses_parsed++;
        if (rsp_if.success !== want.success || rsp_if.address !== want.address ||
            rsp_if.consumed !== want.consumed) begin
          note_error($sformatf(
            "success exp %0b got %0b, address exp %h got %h, consumed exp %0d got %0d",
            want.success, rsp_if.success, want.address, rsp_if.address,
            want.consumed, rsp_if.consumed));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    req_if.valid     <= 1'b0;
    req_if.text_byte <= '0;
    req_if.last_byte <= 1'b0;
    rst_n            <= 1'b0;
    sender_idles     = 1'b1;
    receiver_stalls  = 1'b1;
    bytes_sent       = 0;
    buffers_sent     = 0;
    results_checked  = 0;
    addresses_parsed = 0;
    mismatches       = 0;
    quiet_cycles     = 0;
    clear_parse();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_buffers(1280);
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    test_random_buffers(340);

    wait_for_results();
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0)
      note_error($sformatf("%0d results never arrived", expected_results.size()));
    $display("run: %0d buffers, %0d bytes, %0d results checked", buffers_sent, bytes_sent,
             results_checked);
    $display("run: %0d addresses parsed, %0d buffers rejected, %0d mismatches",
             addresses_parsed, results_checked - addresses_parsed, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
